@@ rtl/core/wmdf_pkg.sv @@
// wmdf_pkg: shared types, codes and constants of the windowed mask distance field core
// no dependencies; used by wmdf_ctrl, wmdf_datapath and the top level
package wmdf_pkg;

  // default grid and window limits
  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;
  localparam int unsigned DEF_MAX_RADIUS = 32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  localparam logic [5:0] RADIUS_RST = 6'd8;
  localparam logic [8:0] WIDTH_RST  = 9'd256;
  localparam logic [8:0] HEIGHT_RST = 9'd256;

  // request opcodes
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  // field widths
  localparam int POS_W    = 8;
  localparam int FV_W     = 16;
  localparam int D2_OUT_W = 12;

  // inverted distance search: smallest k with (s*k)^2 >= d2 * 2^30
  localparam int              K_W          = 16;
  localparam logic [K_W-1:0]  K_FULL       = 16'd32768;
  localparam int              SRCH_ITERS   = 16;
  localparam int              ITER_W       = 4;
  localparam int              TARGET_SHIFT = 30;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_SQ,
    ST_CMP,
    ST_RESULT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic write;
    logic load;
    logic scan;
    logic srch_init;
    logic mul;
    logic sq;
    logic cmp;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic pipe_busy;
    logic need_search;
    logic srch_last;
  } status_t;

endpackage

@@ rtl/core/wmdf_ctrl.sv @@
// wmdf_ctrl: sequencer of the distance field core (clear, write, scan, search, result)
// depends on wmdf_pkg
module wmdf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  wmdf_pkg::status_t  status_i,
  output wmdf_pkg::cmd_t     cmd_o
);

  wmdf_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // state and output flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wmdf_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wmdf_pkg::ST_CLEAR: begin
        if (status_i.clear_last) state_d = wmdf_pkg::ST_IDLE;
      end
      wmdf_pkg::ST_IDLE: begin
        if (accept && (opcode_i == wmdf_pkg::OP_QUERY)) state_d = wmdf_pkg::ST_SCAN;
      end
      wmdf_pkg::ST_SCAN: begin
        if (status_i.scan_last) state_d = wmdf_pkg::ST_DRAIN;
      end
      wmdf_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = status_i.need_search ? wmdf_pkg::ST_MUL : wmdf_pkg::ST_RESULT;
        end
      end
      wmdf_pkg::ST_MUL: state_d = wmdf_pkg::ST_SQ;
      wmdf_pkg::ST_SQ:  state_d = wmdf_pkg::ST_CMP;
      wmdf_pkg::ST_CMP: begin
        state_d = status_i.srch_last ? wmdf_pkg::ST_RESULT : wmdf_pkg::ST_MUL;
      end
      wmdf_pkg::ST_RESULT: begin
        if (out_free) state_d = wmdf_pkg::ST_IDLE;
      end
      default: state_d = wmdf_pkg::ST_CLEAR;
    endcase
  end

  // commands and handshake outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      wmdf_pkg::ST_CLEAR: cmd_o.clear = 1'b1;
      wmdf_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.write = accept && (opcode_i == wmdf_pkg::OP_WRITE);
        cmd_o.load  = accept && (opcode_i == wmdf_pkg::OP_QUERY);
      end
      wmdf_pkg::ST_SCAN:  cmd_o.scan = 1'b1;
      wmdf_pkg::ST_DRAIN: cmd_o.srch_init = !status_i.pipe_busy && status_i.need_search;
      wmdf_pkg::ST_MUL:   cmd_o.mul = 1'b1;
      wmdf_pkg::ST_SQ:    cmd_o.sq = 1'b1;
      wmdf_pkg::ST_CMP:   cmd_o.cmp = 1'b1;
      wmdf_pkg::ST_RESULT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/wmdf_datapath.sv @@
// wmdf_datapath: mask memory, config registers, window scan pipeline and inverted
// distance search; depends on wmdf_pkg
module wmdf_datapath #(
  parameter int unsigned MAX_WIDTH  = wmdf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = wmdf_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_RADIUS = wmdf_pkg::DEF_MAX_RADIUS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wmdf_pkg::cmd_t                    cmd_i,
  output wmdf_pkg::status_t                 status_o,
  input  logic                              cfg_we_i,
  input  logic [wmdf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wmdf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [wmdf_pkg::POS_W-1:0]        pos_x_i,
  input  logic [wmdf_pkg::POS_W-1:0]        pos_y_i,
  input  logic                              mask_bit_i,
  output logic [wmdf_pkg::FV_W-1:0]         field_value_o,
  output logic                              found_o,
  output logic [wmdf_pkg::D2_OUT_W-1:0]     min_dist_sq_o
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int unsigned CMAX0 = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned CMAX  = (CMAX0 > 256 + MAX_RADIUS) ? CMAX0 : 256 + MAX_RADIUS;
  localparam int CW   = $clog2(CMAX + 1);
  localparam int D2W  = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
  localparam int SKW  = RW + wmdf_pkg::K_W;
  localparam int SQW  = 2 * SKW;
  localparam int KW   = wmdf_pkg::K_W;

  // configuration registers
  logic [5:0] radius_q;
  logic [8:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= wmdf_pkg::RADIUS_RST;
      width_q  <= wmdf_pkg::WIDTH_RST;
      height_q <= wmdf_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wmdf_pkg::CFG_RADIUS: radius_q <= cfg_data_i[5:0];
        wmdf_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        wmdf_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturated radius and image size
  logic [RW-1:0] s_sat;
  logic [CW-1:0] w_sat, h_sat;

  always_comb begin
    s_sat = (int'(radius_q) > int'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_q);
    w_sat = (int'(width_q) > int'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_q);
    h_sat = (int'(height_q) > int'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(height_q);
  end

  // clipped window bounds of a new query
  logic [CW-1:0] x0_c, x1_c, y0_c, y1_c;
  logic          empty_c;

  always_comb begin
    int xi, yi, si, wi, hgt;
    xi  = int'(pos_x_i);
    yi  = int'(pos_y_i);
    si  = int'(s_sat);
    wi  = int'(w_sat);
    hgt = int'(h_sat);
    x0_c = (xi - si < 0) ? '0 : CW'(xi - si);
    y0_c = (yi - si < 0) ? '0 : CW'(yi - si);
    x1_c = (xi + si > wi) ? CW'(wi) : CW'(xi + si);
    y1_c = (yi + si > hgt) ? CW'(hgt) : CW'(yi + si);
    empty_c = (x1_c <= x0_c) || (y1_c <= y0_c);
  end

  // query and scan registers
  logic [wmdf_pkg::POS_W-1:0] x_q, y_q;
  logic [RW-1:0]              s_q;
  logic [CW-1:0]              y0_q, x1_q, y1_q, fx_q, fy_q;
  logic                       empty_q;
  logic                       issue;
  logic [CW-1:0]              x1m, y1m;

  assign issue = cmd_i.scan && !empty_q;
  assign x1m   = x1_q - CW'(1);
  assign y1m   = y1_q - CW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= pos_x_i;
      y_q     <= pos_y_i;
      s_q     <= s_sat;
      y0_q    <= y0_c;
      x1_q    <= x1_c;
      y1_q    <= y1_c;
      fx_q    <= x0_c;
      fy_q    <= y0_c;
      empty_q <= empty_c;
    end else if (issue) begin
      if (fy_q == y1m) begin
        fy_q <= y0_q;
        fx_q <= fx_q + CW'(1);
      end else begin
        fy_q <= fy_q + CW'(1);
      end
    end
  end

  // clearing pass counter
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // mask memory, one write port and one registered read port
  logic          mem [DEPTH];
  logic          in_grid;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] rd_addr;
  logic          rd_bit_q;

  assign in_grid   = (int'(pos_x_i) < int'(MAX_WIDTH)) && (int'(pos_y_i) < int'(MAX_HEIGHT));
  assign mem_we    = cmd_i.clear || (cmd_i.write && in_grid);
  assign mem_waddr = cmd_i.clear ? clr_q
                                 : AW'(int'(pos_y_i) * int'(MAX_WIDTH) + int'(pos_x_i));
  assign mem_wdata = cmd_i.clear ? 1'b0 : mask_bit_i;
  assign rd_addr   = AW'(int'(fy_q) * int'(MAX_WIDTH) + int'(fx_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (issue)  rd_bit_q <= mem[rd_addr];
  end

  // scan pipeline: offsets, squared distance, running minimum
  logic          v1_q, v2_q, found_q;
  logic [RW-1:0] dxm_q, dym_q;
  logic [D2W-1:0] d2_q, best_q;
  logic [RW-1:0] dxm_c, dym_c;

  always_comb begin
    int dxi, dyi;
    dxi   = int'(x_q) - int'(fx_q);
    dyi   = int'(y_q) - int'(fy_q);
    dxm_c = (dxi < 0) ? RW'(-dxi) : RW'(dxi);
    dym_c = (dyi < 0) ? RW'(-dyi) : RW'(dyi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q && rd_bit_q;
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end else if (v2_q && (!found_q || (d2_q < best_q))) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      dxm_q <= dxm_c;
      dym_q <= dym_c;
    end
    d2_q <= D2W'(D2W'(dxm_q) * D2W'(dxm_q)) + D2W'(D2W'(dym_q) * D2W'(dym_q));
    if (v2_q && (!found_q || (d2_q < best_q))) best_q <= d2_q;
  end

  // inverted distance binary search, each step runs through the MUL, SQ and CMP states
  logic [KW-1:0]     lo_q, hi_q, mid_q, mid_c;
  logic [KW:0]       sum_c;
  logic [SKW-1:0]    sk_q;
  logic [SQW-1:0]    sq_q, target_q;
  logic [wmdf_pkg::ITER_W-1:0] iter_q;
  logic              need_search;

  assign sum_c = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_c = sum_c[KW:1];
  assign need_search = found_q && (int'(best_q) < int'(s_q) * int'(s_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_init) begin
      lo_q     <= '0;
      hi_q     <= wmdf_pkg::K_FULL;
      iter_q   <= '0;
      target_q <= SQW'(best_q) << wmdf_pkg::TARGET_SHIFT;
    end
    if (cmd_i.mul) begin
      mid_q <= mid_c;
      sk_q  <= SKW'(s_q) * SKW'(mid_c);
    end
    if (cmd_i.sq) sq_q <= SQW'(sk_q) * SQW'(sk_q);
    if (cmd_i.cmp) begin
      iter_q <= iter_q + wmdf_pkg::ITER_W'(1);
      if (lo_q < hi_q) begin
        if (sq_q >= target_q) hi_q <= mid_q;
        else                  lo_q <= mid_q + KW'(1);
      end
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      found_o       <= found_q;
      min_dist_sq_o <= found_q ? wmdf_pkg::D2_OUT_W'(best_q) : '0;
      field_value_o <= need_search ? wmdf_pkg::FV_W'(wmdf_pkg::K_FULL - lo_q) : '0;
    end
  end

  // status to controller
  assign status_o.clear_last  = (clr_q == AW'(DEPTH - 1));
  assign status_o.scan_last   = empty_q || ((fx_q == x1m) && (fy_q == y1m));
  assign status_o.pipe_busy   = v1_q || v2_q;
  assign status_o.need_search = need_search;
  assign status_o.srch_last   = (iter_q == wmdf_pkg::ITER_W'(wmdf_pkg::SRCH_ITERS - 1));

endmodule

@@ rtl/core/windowed_mask_distance_field_core.sv @@
// windowed_mask_distance_field_core: a write request is stored in the cycle it is taken; a query
// request scans n clipped window pixels, up to (2*MAX_RADIUS)^2, one mask read per cycle
// from the single read port; the search adds 16 steps through MUL, SQ and CMP only when a set
// pixel lies inside the radius. One request at a time; the result register frees the input.
// Reset: config and control registers return to defaults and the mask is cleared by a pass
// over all MAX_WIDTH*MAX_HEIGHT cells (65536 by default) before the first request is taken.
module windowed_mask_distance_field_core #(
  parameter int unsigned MAX_WIDTH  = wmdf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = wmdf_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_RADIUS = wmdf_pkg::DEF_MAX_RADIUS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            opcode_i,
  input  logic [wmdf_pkg::POS_W-1:0]      pos_x_i,
  input  logic [wmdf_pkg::POS_W-1:0]      pos_y_i,
  input  logic                            mask_bit_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [wmdf_pkg::FV_W-1:0]       field_value_o,
  output logic                            found_o,
  output logic [wmdf_pkg::D2_OUT_W-1:0]   min_dist_sq_o,
  input  logic                            cfg_we_i,
  input  logic [wmdf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wmdf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  wmdf_pkg::cmd_t    cmd;
  wmdf_pkg::status_t status;

  // sequencer
  wmdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // mask store and arithmetic
  wmdf_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .mask_bit_i   (mask_bit_i),
    .field_value_o(field_value_o),
    .found_o      (found_o),
    .min_dist_sq_o(min_dist_sq_o)
  );

  // nothing found gives an all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (field_value_o == '0) && (min_dist_sq_o == '0))
    else $error("empty result carries non-zero fields");

  // field value never exceeds 1.0 (K_FULL)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (field_value_o <= wmdf_pkg::K_FULL))
    else $error("field value out of range");

  // a taken query request drops in_ready_o, since the block leaves the idle state for the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == wmdf_pkg::OP_QUERY) |=> !in_ready_o)
    else $error("request taken while a query is in progress");

endmodule
